// ----- design/nlos_pkg.sv -----
// Package for natural_log_odd_series: fixed formats and constants.
// No dependencies; used by scoped name from the top level.
`default_nettype none
package nlos_pkg;
  // fraction bits of the argument and of the quotient t
  localparam int unsigned FRAC_BITS = 30;
  localparam int unsigned T_FRAC = 30;
  localparam logic [63:0] SQRT_HALF_Q64 = 64'hB504F333F9DE6484;
  localparam logic [31:0] LN2_HALF_Q28 = 32'd93032640;
  localparam logic [31:0] COEF_T1_RST = 32'd2147483641;
  localparam logic [31:0] COEF_T3_RST = 32'd715830893;
  localparam logic [31:0] COEF_T5_RST = 32'd429130692;
  localparam logic [31:0] COEF_T7_RST = 32'd323168916;
  localparam logic [1:0] REG_T1 = 2'd0;
  localparam logic [1:0] REG_T3 = 2'd1;
  localparam logic [1:0] REG_T5 = 2'd2;
  localparam logic [1:0] REG_T7 = 2'd3;
endpackage
`default_nettype wire

// ----- design/natural_log_odd_series.sv -----
// natural_log_odd_series: pipelined ln(x) by t=(x-c)/(x+c) and odd polynomial.
// Depends on nlos_pkg.
//
//   channel | ports                               | handshake
//   in      | in_x_value[31:0]                    | in_valid / in_ready
//   out     | out_ln_value[31:0], out_in_domain   | out_valid / out_ready
//   cfg     | psel penable pwrite paddr pwdata    | pready (always high)
//
// One item per cycle sustained while the output is not stalled. Stages: input
// stage, one stage per quotient bit of the restoring divider, four power
// stages, the term stage, then sum and output register.
// Reset (synchronous, rst_n low) clears all valid bits and loads coefficients.
// A stall at the output freezes the whole pipe in place; no item is lost.
`default_nettype none
module natural_log_odd_series (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_x_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_ln_value,
  output logic             out_in_domain,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  localparam int unsigned FRAC_BITS = nlos_pkg::FRAC_BITS;
  localparam int unsigned TF = nlos_pkg::T_FRAC;
  localparam int unsigned ND = TF;            // divider stages
  localparam int unsigned SH = FRAC_BITS + TF - 28;
  localparam logic [63:0] C_W =
    ((nlos_pkg::SQRT_HALF_Q64 >> (63 - FRAC_BITS)) + 64'd1) >> 1;
  localparam logic [63:0] C2_W =
    ((nlos_pkg::SQRT_HALF_Q64 >> (62 - FRAC_BITS)) + 64'd1) >> 1;
  localparam logic [33:0] C_V  = C_W[33:0];
  localparam logic [33:0] C2_V = C2_W[33:0];
  localparam logic [63:0] HALF30 = 64'd1 << (TF - 1);
  localparam logic [127:0] HALF_SH = 128'd1 << (SH - 1);

  // config registers
  logic [31:0] coef1_r, coef3_r, coef5_r, coef7_r;
  logic        wr;
  logic [1:0]  ridx;
  assign pready = 1'b1;
  assign ridx   = paddr[3:2];
  assign wr     = psel && penable && pwrite;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef1_r <= nlos_pkg::COEF_T1_RST;
      coef3_r <= nlos_pkg::COEF_T3_RST;
      coef5_r <= nlos_pkg::COEF_T5_RST;
      coef7_r <= nlos_pkg::COEF_T7_RST;
    end else if (wr) begin
      unique case (ridx)
        nlos_pkg::REG_T1: coef1_r <= pwdata;
        nlos_pkg::REG_T3: coef3_r <= pwdata;
        nlos_pkg::REG_T5: coef5_r <= pwdata;
        nlos_pkg::REG_T7: coef7_r <= pwdata;
        default: ;
      endcase
    end
  end
  always_comb begin
    unique case (ridx)
      nlos_pkg::REG_T1: prdata = coef1_r;
      nlos_pkg::REG_T3: prdata = coef3_r;
      nlos_pkg::REG_T5: prdata = coef5_r;
      default:          prdata = coef7_r;
    endcase
  end

  // global advance: whole pipe moves when output slot is free or taken
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // stage 0: sign, numerator, denominator, domain flag
  logic        v0_r, neg0_r, dom0_r;
  logic [33:0] num0_r, den0_r;
  logic [33:0] xw;
  assign xw = {2'b00, in_x_value};
  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else if (adv) v0_r <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      neg0_r <= xw < C_V;
      num0_r <= (xw < C_V) ? C_V - xw : xw - C_V;
      den0_r <= xw + C_V;
      dom0_r <= (xw >= C_V) && (xw <= C2_V);
    end
  end

  // divider: one quotient bit per stage, plus saturation flag for num >= den
  logic           dv_r   [ND+1];
  logic           dneg_r [ND+1];
  logic           ddom_r [ND+1];
  logic           dsat_r [ND+1];
  logic [34:0]    drem_r [ND+1];
  logic [33:0]    dden_r [ND+1];
  logic [TF-1:0]  dq_r   [ND+1];
  always_comb begin
    dv_r[0]   = v0_r;
    dneg_r[0] = neg0_r;
    ddom_r[0] = dom0_r;
    dsat_r[0] = num0_r >= den0_r;
    drem_r[0] = {1'b0, num0_r};
    dden_r[0] = den0_r;
    dq_r[0]   = '0;
  end
  for (genvar g = 0; g < ND; g++) begin : g_div
    logic [34:0] sh_w;
    logic        ge_w;
    assign sh_w = {drem_r[g][33:0], 1'b0};
    assign ge_w = sh_w >= {1'b0, dden_r[g]};
    always_ff @(posedge clk) begin
      if (!rst_n) dv_r[g+1] <= 1'b0;
      else if (adv) dv_r[g+1] <= dv_r[g];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dneg_r[g+1] <= dneg_r[g];
        ddom_r[g+1] <= ddom_r[g];
        dsat_r[g+1] <= dsat_r[g];
        dden_r[g+1] <= dden_r[g];
        drem_r[g+1] <= ge_w ? sh_w - {1'b0, dden_r[g]} : sh_w;
        dq_r[g+1]   <= {dq_r[g][TF-2:0], ge_w};
      end
    end
  end

  // power stages: m2, m3, m5, m7 (each Q1.30, fits 31 bits)
  logic        p1v_r, p2v_r, p3v_r, p4v_r;
  logic        p1n_r, p2n_r, p3n_r, p4n_r;
  logic        p1d_r, p2d_r, p3d_r, p4d_r;
  logic [30:0] m1_r, m1b_r, m1c_r, m1d_r;
  logic [30:0] m2_r, m2b_r, m2c_r, m3_r, m3b_r, m3c_r, m5_r, m5b_r, m7_r;
  logic [30:0] mq;
  assign mq = dsat_r[ND] ? 31'(64'd1 << TF) : {1'b0, dq_r[ND]};

  function automatic logic [30:0] mulq(input logic [30:0] a, input logic [30:0] b);
    logic [63:0] p;
    p = ({33'd0, a} * {33'd0, b}) + HALF30;
    return 31'(p >> TF);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1v_r <= 1'b0; p2v_r <= 1'b0; p3v_r <= 1'b0; p4v_r <= 1'b0;
    end else if (adv) begin
      p1v_r <= dv_r[ND]; p2v_r <= p1v_r; p3v_r <= p2v_r; p4v_r <= p3v_r;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      p1n_r <= dneg_r[ND]; p1d_r <= ddom_r[ND];
      m1_r  <= mq;
      m2_r  <= mulq(mq, mq);
      p2n_r <= p1n_r; p2d_r <= p1d_r; m1b_r <= m1_r; m2b_r <= m2_r;
      m3_r  <= mulq(m2_r, m1_r);
      p3n_r <= p2n_r; p3d_r <= p2d_r; m1c_r <= m1b_r; m2c_r <= m2b_r;
      m3b_r <= m3_r;
      m5_r  <= mulq(m3_r, m2b_r);
      p4n_r <= p3n_r; p4d_r <= p3d_r; m1d_r <= m1c_r; m3c_r <= m3b_r;
    end
  end
  // keep m5 aligned to the last power stage and form m7 there
  always_ff @(posedge clk) begin
    if (adv) begin
      m5b_r <= m5_r;
      m7_r  <= mulq(m5_r, m2c_r);
    end
  end

  // term stage: coef * m^k rounded to Q.28
  logic        tv_r, tn_r, td_r;
  logic [35:0] t1_r, t3_r, t5_r, t7_r;
  function automatic logic [35:0] term(input logic [31:0] c, input logic [30:0] m);
    logic [127:0] p;
    p = ({96'd0, c} * {97'd0, m}) + HALF_SH;
    return 36'(p >> SH);
  endfunction
  always_ff @(posedge clk) begin
    if (!rst_n) tv_r <= 1'b0;
    else if (adv) tv_r <= p4v_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      tn_r <= p4n_r; td_r <= p4d_r;
      t1_r <= term(coef1_r, m1d_r);
      t3_r <= term(coef3_r, m3c_r);
      t5_r <= term(coef5_r, m5b_r);
      t7_r <= term(coef7_r, m7_r);
    end
  end

  // sum, sign, offset, saturate; output register
  logic [37:0] sum_w;
  logic signed [39:0] res_w;
  assign sum_w = {2'b0, t1_r} + {2'b0, t3_r} + {2'b0, t5_r} + {2'b0, t7_r};
  assign res_w = (tn_r ? -$signed({2'b0, sum_w}) : $signed({2'b0, sum_w}))
               - $signed({8'd0, nlos_pkg::LN2_HALF_Q28});
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else if (adv) out_valid <= tv_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      out_in_domain <= td_r;
      if (res_w > 40'sd2147483647) out_ln_value <= 32'h7FFFFFFF;
      else if (res_w < -40'sd2147483648) out_ln_value <= 32'h80000000;
      else out_ln_value <= res_w[31:0];
    end
  end
endmodule
`default_nettype wire

// ----- design/nlos_checker.sv -----
// Port-level checker for natural_log_odd_series, bound to the top level.
// No dependencies.
`default_nettype none
module nlos_sva (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic pready
);
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready)) else $error("ready mismatch");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_pready: assert property (@(posedge clk) pready) else $error("pready low");
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("valid after reset");
endmodule
bind natural_log_odd_series nlos_sva u_chk (.*);
`default_nettype wire

// ----- tb/sv/nlos_checker.sv -----
// Checker for natural_log_odd_series: predicts ln_value and in_domain per item.
// Depends on nlos_pkg; watches the in, out and cfg ports of the block.
module nlos_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [31:0] in_x_value,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] out_ln_value,
  input  logic        out_in_domain,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          mismatch_count,
  output int          pending_count
);
  typedef struct packed {
    logic signed [31:0] ln_value;
    logic               in_domain;
  } ln_result_t;

  logic [31:0] coef [4];
  ln_result_t  ln_queue [$];

  function automatic logic [63:0] round_q30(logic [63:0] a, logic [63:0] b);
    return (a * b + (64'd1 << (nlos_pkg::T_FRAC - 1))) >> nlos_pkg::T_FRAC;
  endfunction

  function automatic logic signed [63:0] scaled_term(logic [31:0] c, logic [63:0] pw);
    logic [63:0] p;
    p = {32'd0, c} * pw;
    return $signed((p + (64'd1 << 31)) >> 32);
  endfunction

  function automatic ln_result_t predict_ln(logic [31:0] x_in);
    logic [63:0] x, c, c2, num, den, m, m2, m3, m5, m7;
    logic signed [63:0] sum;
    logic neg;
    ln_result_t r;
    x = {32'd0, x_in};
    c = ((nlos_pkg::SQRT_HALF_Q64 >> 33) + 64'd1) >> 1;
    c2 = ((nlos_pkg::SQRT_HALF_Q64 >> 32) + 64'd1) >> 1;
    neg = x < c;
    num = neg ? c - x : x - c;
    den = x + c;
    if (num >= den) m = 64'd1 << nlos_pkg::T_FRAC;
    else m = (num << nlos_pkg::T_FRAC) / den;
    m2 = round_q30(m, m);
    m3 = round_q30(m2, m);
    m5 = round_q30(m3, m2);
    m7 = round_q30(m5, m2);
    sum = scaled_term(coef[nlos_pkg::REG_T1], m) + scaled_term(coef[nlos_pkg::REG_T3], m3)
        + scaled_term(coef[nlos_pkg::REG_T5], m5) + scaled_term(coef[nlos_pkg::REG_T7], m7);
    if (neg) sum = -sum;
    sum = sum - $signed({32'd0, nlos_pkg::LN2_HALF_Q28});
    if (sum > 64'sd2147483647) sum = 64'sd2147483647;
    if (sum < -64'sd2147483648) sum = -64'sd2147483648;
    r.ln_value = sum[31:0];
    r.in_domain = (x >= c) && (x <= c2);
    return r;
  endfunction

  always @(posedge clk) begin
    ln_result_t want;
    int errs;
    errs = 0;
    if (!rst_n) begin
      coef[nlos_pkg::REG_T1] = nlos_pkg::COEF_T1_RST;
      coef[nlos_pkg::REG_T3] = nlos_pkg::COEF_T3_RST;
      coef[nlos_pkg::REG_T5] = nlos_pkg::COEF_T5_RST;
      coef[nlos_pkg::REG_T7] = nlos_pkg::COEF_T7_RST;
      ln_queue.delete();
      mismatch_count <= 0;
    end else begin
      if (psel && penable && pwrite && pready)
        coef[paddr[3:2]] = pwdata;
      if (in_valid && in_ready) ln_queue.push_back(predict_ln(in_x_value));
      if (out_valid && out_ready) begin
        if (ln_queue.size() == 0) begin
          $error("unexpected item: ln_value %0d", $signed(out_ln_value));
          errs++;
        end else begin
          want = ln_queue.pop_front();
          if (out_ln_value !== want.ln_value) begin
            $error("ln_value expected %0d actual %0d", want.ln_value,
                   $signed(out_ln_value));
            errs++;
          end
          if (out_in_domain !== want.in_domain) begin
            $error("in_domain expected %0d actual %0d", want.in_domain, out_in_domain);
            errs++;
          end
        end
      end
      mismatch_count <= mismatch_count + errs;
    end
    pending_count <= ln_queue.size();
  end
endmodule

// ----- tb/sv/tb.sv -----
// Top of the natural_log_odd_series testbench: clock, reset, stimulus, verdict.
// Depends on nlos_pkg, natural_log_odd_series and nlos_checker.
module tb;
  localparam logic [31:0] C_LO = 32'h2D413CCD; // sqrt(2)/2 in Q2.30
  localparam logic [31:0] C_HI = 32'h5A82799A; // sqrt(2) in Q2.30
  localparam int PIPE_DEPTH = nlos_pkg::T_FRAC + 9;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_x_value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_ln_value;
  logic        out_in_domain;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          mismatch_count;
  int          pending_count;

  // Shared knobs for the idle patterns of both sides.
  bit          send_burst = 1'b0;
  bit          drain_burst = 1'b0;
  bit          backlog_req = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  natural_log_odd_series dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_x_value, .out_valid, .out_ready,
    .out_ln_value, .out_in_domain, .psel, .penable, .pwrite, .paddr, .pwdata,
    .prdata, .pready
  );

  nlos_checker ln_check (
    .clk, .rst_n, .in_valid, .in_ready, .in_x_value, .out_valid, .out_ready,
    .out_ln_value, .out_in_domain, .psel, .penable, .pwrite, .paddr, .pwdata,
    .pready, .mismatch_count, .pending_count
  );

  // Offer one item after a random gap; hold it until the block takes it.
  task automatic send_x(logic [31:0] x);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_x_value <= x;
    do @(posedge clk); while (!in_ready);
  endtask

  // Draw an argument: mostly inside the domain, some near its edges, rest anywhere.
  function automatic logic [31:0] pick_x();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return $urandom_range(C_HI, C_LO);
    if (sel < 7) return C_LO + $urandom_range(0, 4) - 2;
    if (sel < 8) return C_HI + $urandom_range(0, 4) - 2;
    return $urandom;
  endfunction

  // Wait for every expected item, then let the pipe settle before a write.
  task automatic drain_pipe();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (PIPE_DEPTH + 4) @(posedge clk);
  endtask

  // One APB write: setup cycle, then access cycle.
  task automatic write_coef(logic [1:0] idx, logic [31:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic load_coefs(logic [31:0] a1, logic [31:0] a3, logic [31:0] a5,
                            logic [31:0] a7);
    write_coef(nlos_pkg::REG_T1, a1);
    write_coef(nlos_pkg::REG_T3, a3);
    write_coef(nlos_pkg::REG_T5, a5);
    write_coef(nlos_pkg::REG_T7, a7);
  endtask

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) begin
      // Switch to back-to-back traffic on one side or both now and then.
      if (i % 60 == 0) begin
        send_burst = ($urandom_range(0, 2) == 0);
        drain_burst = ($urandom_range(0, 2) == 0);
      end
      send_x(pick_x());
    end
    send_burst = 1'b0;
    drain_burst = 1'b0;
  endtask

  // Receiver: random stall per item, plus one long hold-off on request.
  initial begin
    int stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (backlog_req) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        backlog_req = 1'b0;
      end
      stall = drain_burst ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Stimulus and verdict.
  initial begin
    int spin;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: field extremes, domain edges, zero argument, round values.
    send_x(32'h0000_0000);
    send_x(32'hFFFF_FFFF);
    send_x(32'h0000_0001);
    send_x(32'h8000_0000);
    send_x(32'h7FFF_FFFF);
    send_x(32'h4000_0000);
    send_x(C_LO - 1);
    send_x(C_LO);
    send_x(C_LO + 1);
    send_x(C_HI - 1);
    send_x(C_HI);
    send_x(C_HI + 1);
    send_x(32'hAAAA_AAAA);
    send_x(32'h5555_5555);
    send_x(32'hC000_0000);
    drain_pipe();

    // Max coefficients push the sum toward saturation on both sides.
    load_coefs('1, '1, '1, '1);
    send_x(32'h0000_0000);
    send_x(32'hFFFF_FFFF);
    send_x(32'h0000_0001);
    send_x(C_LO);
    send_x(C_HI);
    random_phase(200);
    drain_pipe();

    // Zero coefficients: result is the bare offset.
    load_coefs('0, '0, '0, '0);
    send_x(32'h0000_0000);
    send_x(32'hFFFF_FFFF);
    random_phase(150);
    drain_pipe();

    // Default values again; ask for a long output stall mid-phase.
    load_coefs(nlos_pkg::COEF_T1_RST, nlos_pkg::COEF_T3_RST, nlos_pkg::COEF_T5_RST,
               nlos_pkg::COEF_T7_RST);
    random_phase(100);
    backlog_req = 1'b1;
    send_burst = 1'b1;
    for (int i = 0; i < 120; i++) send_x(pick_x());
    send_burst = 1'b0;
    random_phase(400);
    drain_pipe();

    // A few random coefficient sets.
    for (int k = 0; k < 3; k++) begin
      load_coefs($urandom, $urandom, $urandom, $urandom);
      random_phase(180);
      drain_pipe();
    end

    spin = 0;
    while (pending_count != 0 && spin < 20000) begin
      @(posedge clk);
      spin++;
    end
    repeat (PIPE_DEPTH + 10) @(posedge clk);
    if (mismatch_count == 0 && pending_count == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #4000000;
    $display("tb failed");
    $finish;
  end
endmodule

// ----- files.f -----
design/nlos_pkg.sv
design/natural_log_odd_series.sv
design/nlos_checker.sv
tb/sv/nlos_checker.sv
tb/sv/tb.sv
